// ----- sv/cma_pkg.sv -----
// Shared types, constants and command/status structs for the contact manifold accumulator.
package cma_pkg;

  localparam int unsigned MaxPoints  = 8;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned CntW       = 4;
  localparam int unsigned PsumW      = 35;
  localparam int unsigned NsumW      = 19;
  localparam int unsigned MdivSteps  = 35;
  localparam int unsigned SqrtSteps  = 31;
  localparam int unsigned NdivSteps  = 46;
  localparam int unsigned StepW      = 6;

  localparam logic [1:0] StAdded   = 2'd0;
  localparam logic [1:0] StDup     = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StCleared = 2'd3;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpClear = 1'b1;

  localparam logic [30:0] DepthOnes = 31'h7FFF_FFFF;
  localparam logic [30:0] MergeDistReset = 31'd66;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] depth;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         contact_count;
    logic [30:0]        largest_depth;
    logic [30:0]        smallest_depth;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic signed [31:0] mean_z;
    logic signed [15:0] unit_normal_x;
    logic signed [15:0] unit_normal_y;
    logic signed [15:0] unit_normal_z;
    logic               normal_valid;
  } out_t;

  typedef struct packed {
    logic            load;
    logic            lim;
    logic            pt_start;
    logic            diff;
    logic            sqr;
    logic            upd;
    logic            st_we;
    logic [1:0]      st_val;
    logic            minit;
    logic            mdiv;
    logic            nsq;
    logic            sinit;
    logic            sqrt;
    logic            dinit;
    logic            ndiv;
    logic            out_load;
    logic [IdxW-1:0] idx;
    logic [1:0]      comp;
  } cmd_t;

  typedef struct packed {
    logic            op_clear;
    logic            full;
    logic [CntW-1:0] count;
    logic            dup_hit;
  } stat_t;

endpackage

// ----- sv/cma_ctrl.sv -----
// Sequencing state machine for the contact manifold accumulator.
module cma_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  cma_pkg::stat_t  stat_i,
  output cma_pkg::cmd_t   cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LIM   = 14'b00000000000010,
    S_DIFF  = 14'b00000000000100,
    S_SQR   = 14'b00000000001000,
    S_CHK   = 14'b00000000010000,
    S_UPD   = 14'b00000000100000,
    S_MINIT = 14'b00000001000000,
    S_MDIV  = 14'b00000010000000,
    S_NSQ   = 14'b00000100000000,
    S_SINIT = 14'b00001000000000,
    S_SQRT  = 14'b00010000000000,
    S_DINIT = 14'b00100000000000,
    S_NDIV  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [cma_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [1:0]                comp_q, comp_d;
  logic [cma_pkg::StepW-1:0] step_q, step_d;
  logic                      ovalid_q, ovalid_d;
  logic                      last_pt;

  assign last_pt = ({1'b0, idx_q} + 4'd1) == stat_i.count;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    comp_d   = comp_q;
    step_d   = step_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    cmd_o.idx  = idx_q;
    cmd_o.comp = comp_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_LIM;
        end
      end
      S_LIM: begin
        cmd_o.lim      = 1'b1;
        cmd_o.pt_start = 1'b1;
        idx_d  = '0;
        comp_d = '0;
        if (stat_i.op_clear) begin
          state_d = S_UPD;
        end else if (stat_i.full) begin
          cmd_o.st_we  = 1'b1;
          cmd_o.st_val = cma_pkg::StFull;
          state_d = S_MINIT;
        end else if (stat_i.count == '0) begin
          state_d = S_UPD;
        end else begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = S_SQR;
      end
      S_SQR: begin
        cmd_o.sqr = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = S_CHK;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_DIFF;
        end
      end
      S_CHK: begin
        comp_d = '0;
        if (stat_i.dup_hit) begin
          cmd_o.st_we  = 1'b1;
          cmd_o.st_val = cma_pkg::StDup;
          state_d = S_MINIT;
        end else if (last_pt) begin
          state_d = S_UPD;
        end else begin
          cmd_o.pt_start = 1'b1;
          idx_d   = idx_q + 3'd1;
          state_d = S_DIFF;
        end
      end
      S_UPD: begin
        cmd_o.upd   = 1'b1;
        cmd_o.st_we = 1'b1;
        cmd_o.st_val = stat_i.op_clear ? cma_pkg::StCleared : cma_pkg::StAdded;
        state_d = S_MINIT;
      end
      S_MINIT: begin
        cmd_o.minit = 1'b1;
        step_d  = '0;
        state_d = S_MDIV;
      end
      S_MDIV: begin
        cmd_o.mdiv = 1'b1;
        step_d = step_q + 6'd1;
        if (step_q == 6'(cma_pkg::MdivSteps - 1)) begin
          comp_d  = '0;
          state_d = S_NSQ;
        end
      end
      S_NSQ: begin
        cmd_o.nsq = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = S_SINIT;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      S_SINIT: begin
        cmd_o.sinit = 1'b1;
        step_d  = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt = 1'b1;
        step_d = step_q + 6'd1;
        if (step_q == 6'(cma_pkg::SqrtSteps - 1)) begin
          state_d = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd_o.dinit = 1'b1;
        step_d  = '0;
        state_d = S_NDIV;
      end
      S_NDIV: begin
        cmd_o.ndiv = 1'b1;
        step_d = step_q + 6'd1;
        if (step_q == 6'(cma_pkg::NdivSteps - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      comp_q   <= '0;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      comp_q   <= comp_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

endmodule

// ----- sv/cma_dp.sv -----
// Datapath: point store, running sums, duplicate check and iterative divide/sqrt units.
module cma_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [30:0]    cfg_wdata_i,
  input  cma_pkg::in_t   in_data_i,
  input  cma_pkg::cmd_t  cmd_i,
  output cma_pkg::stat_t stat_o,
  output cma_pkg::out_t  out_data_o
);

  cma_pkg::in_t  in_q;
  cma_pkg::out_t out_q;

  logic [30:0] lim_q;
  logic [61:0] lim2_q;
  logic signed [31:0] sx_q [cma_pkg::MaxPoints];
  logic signed [31:0] sy_q [cma_pkg::MaxPoints];
  logic signed [31:0] sz_q [cma_pkg::MaxPoints];
  logic [cma_pkg::CntW-1:0] count_q;
  logic signed [cma_pkg::PsumW-1:0] psum_q [3];
  logic signed [cma_pkg::NsumW-1:0] nsum_q [3];
  logic [30:0] maxd_q, mind_q;
  logic [1:0]  status_q;

  logic [30:0] mag_q;
  logic        far_q;
  logic [63:0] acc_q;

  logic [cma_pkg::PsumW-1:0] mq_q [3];
  logic [3:0]                mr_q [3];
  logic                      mneg_q [3];

  logic [37:0] m2_q;
  logic [61:0] sn_q;
  logic [32:0] sr_q;
  logic [30:0] root_q;

  logic [45:0] nq_q [3];
  logic [30:0] nr_q [3];
  logic        nneg_q [3];

  cma_pkg::out_t out_next;
  logic [31:0]   mean_v [3];
  logic [15:0]   unit_v [3];
  logic          nz;

  // Duplicate distance: magnitude of one coordinate difference.
  logic signed [31:0] pcur, scur;
  logic signed [32:0] dif;
  logic [32:0]        dmag;

  always_comb begin
    case (cmd_i.comp)
      2'd0:    begin pcur = in_q.point_x; scur = sx_q[cmd_i.idx]; end
      2'd1:    begin pcur = in_q.point_y; scur = sy_q[cmd_i.idx]; end
      default: begin pcur = in_q.point_z; scur = sz_q[cmd_i.idx]; end
    endcase
    dif  = {pcur[31], pcur} - {scur[31], scur};
    dmag = dif[32] ? 33'(-dif) : 33'(dif);
  end

  // Depth magnitude, saturating the most negative code.
  logic [30:0] dabs;
  logic [31:0] dneg;
  always_comb begin
    dneg = -in_q.depth;
    if (in_q.depth == 32'sh8000_0000) begin
      dabs = cma_pkg::DepthOnes;
    end else if (in_q.depth[31]) begin
      dabs = dneg[30:0];
    end else begin
      dabs = in_q.depth[30:0];
    end
  end

  // Normal component magnitude for the squaring step.
  logic signed [cma_pkg::NsumW-1:0] ncur;
  logic [cma_pkg::NsumW-1:0]        nmag;
  always_comb begin
    case (cmd_i.comp)
      2'd0:    ncur = nsum_q[0];
      2'd1:    ncur = nsum_q[1];
      default: ncur = nsum_q[2];
    endcase
    nmag = ncur[cma_pkg::NsumW-1] ? 19'(-ncur) : 19'(ncur);
  end

  // Full-width squares of the difference and normal magnitudes.
  logic [61:0] dsq_v;
  logic [37:0] nsq_v;
  assign dsq_v = mag_q * mag_q;
  assign nsq_v = nmag * nmag;

  // One root step consumes two radicand bits.
  logic [34:0] srem_sh, strial;
  assign srem_sh = {sr_q, sn_q[61:60]};
  assign strial  = {2'b00, root_q, 2'b01};

  assign stat_o.op_clear = (in_q.operation == cma_pkg::OpClear);
  assign stat_o.full     = (count_q >= 4'(cma_pkg::MaxPoints));
  assign stat_o.count    = count_q;
  assign stat_o.dup_hit  = !far_q && (acc_q < {2'b00, lim2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q    <= cma_pkg::MergeDistReset;
      count_q  <= '0;
      maxd_q   <= '0;
      mind_q   <= cma_pkg::DepthOnes;
      for (int k = 0; k < 3; k++) begin
        psum_q[k] <= '0;
        nsum_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      if (cmd_i.upd) begin
        if (in_q.operation == cma_pkg::OpClear) begin
          count_q <= '0;
          maxd_q  <= '0;
          mind_q  <= cma_pkg::DepthOnes;
          for (int k = 0; k < 3; k++) begin
            psum_q[k] <= '0;
            nsum_q[k] <= '0;
          end
        end else begin
          count_q   <= count_q + 4'd1;
          psum_q[0] <= psum_q[0] + 35'(in_q.point_x);
          psum_q[1] <= psum_q[1] + 35'(in_q.point_y);
          psum_q[2] <= psum_q[2] + 35'(in_q.point_z);
          nsum_q[0] <= nsum_q[0] + 19'(in_q.normal_x);
          nsum_q[1] <= nsum_q[1] + 19'(in_q.normal_y);
          nsum_q[2] <= nsum_q[2] + 19'(in_q.normal_z);
          if (dabs > maxd_q) begin
            maxd_q <= dabs;
          end
          if (dabs < mind_q) begin
            mind_q <= dabs;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.upd && in_q.operation == cma_pkg::OpAdd) begin
      sx_q[count_q[cma_pkg::IdxW-1:0]] <= in_q.point_x;
      sy_q[count_q[cma_pkg::IdxW-1:0]] <= in_q.point_y;
      sz_q[count_q[cma_pkg::IdxW-1:0]] <= in_q.point_z;
    end
    if (cmd_i.st_we) begin
      status_q <= cmd_i.st_val;
    end
    if (cmd_i.lim) begin
      lim2_q <= lim_q * lim_q;
    end
    if (cmd_i.pt_start) begin
      acc_q <= '0;
      far_q <= 1'b0;
    end
    if (cmd_i.diff) begin
      mag_q <= dmag[30:0];
      if (dmag >= {2'b00, lim_q}) begin
        far_q <= 1'b1;
      end
    end
    if (cmd_i.sqr && !far_q) begin
      acc_q <= acc_q + 64'(dsq_v);
    end

    // Mean: restoring division of the three sum magnitudes by the count.
    if (cmd_i.minit) begin
      m2_q <= '0;
      for (int k = 0; k < 3; k++) begin
        mneg_q[k] <= psum_q[k][cma_pkg::PsumW-1];
        mq_q[k]   <= psum_q[k][cma_pkg::PsumW-1] ? 35'(-psum_q[k]) : 35'(psum_q[k]);
        mr_q[k]   <= '0;
      end
    end
    if (cmd_i.mdiv) begin
      for (int k = 0; k < 3; k++) begin
        if ({mr_q[k], mq_q[k][cma_pkg::PsumW-1]} >= {1'b0, count_q}) begin
          mr_q[k] <= 4'({mr_q[k], mq_q[k][cma_pkg::PsumW-1]} - {1'b0, count_q});
          mq_q[k] <= {mq_q[k][cma_pkg::PsumW-2:0], 1'b1};
        end else begin
          mr_q[k] <= {mr_q[k][2:0], mq_q[k][cma_pkg::PsumW-1]};
          mq_q[k] <= {mq_q[k][cma_pkg::PsumW-2:0], 1'b0};
        end
      end
    end

    if (cmd_i.nsq) begin
      m2_q <= m2_q + nsq_v;
    end
    if (cmd_i.sinit) begin
      sn_q   <= {m2_q, 24'd0};
      sr_q   <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt) begin
      sn_q <= {sn_q[59:0], 2'b00};
      if (srem_sh >= strial) begin
        sr_q   <= 33'(srem_sh - strial);
        root_q <= {root_q[29:0], 1'b1};
      end else begin
        sr_q   <= srem_sh[32:0];
        root_q <= {root_q[29:0], 1'b0};
      end
    end

    // Unit normal: restoring division of |sum| * 2^27 by the root.
    if (cmd_i.dinit) begin
      for (int k = 0; k < 3; k++) begin
        nneg_q[k] <= nsum_q[k][cma_pkg::NsumW-1];
        nq_q[k]   <= {(nsum_q[k][cma_pkg::NsumW-1] ? 19'(-nsum_q[k]) : 19'(nsum_q[k])),
                      27'd0};
        nr_q[k]   <= '0;
      end
    end
    if (cmd_i.ndiv) begin
      for (int k = 0; k < 3; k++) begin
        if ({nr_q[k], nq_q[k][45]} >= {1'b0, root_q}) begin
          nr_q[k] <= 31'({nr_q[k], nq_q[k][45]} - {1'b0, root_q});
          nq_q[k] <= {nq_q[k][44:0], 1'b1};
        end else begin
          nr_q[k] <= {nr_q[k][29:0], nq_q[k][45]};
          nq_q[k] <= {nq_q[k][44:0], 1'b0};
        end
      end
    end

    if (cmd_i.out_load) begin
      out_q <= out_next;
    end
  end

  always_comb begin
    nz = (m2_q != '0);
    for (int k = 0; k < 3; k++) begin
      if (count_q == '0) begin
        mean_v[k] = '0;
      end else if (mneg_q[k]) begin
        mean_v[k] = 32'(-mq_q[k]);
      end else begin
        mean_v[k] = mq_q[k][31:0];
      end
      if (!nz) begin
        unit_v[k] = '0;
      end else if (nneg_q[k]) begin
        unit_v[k] = (nq_q[k] > 46'd32768) ? 16'h8000 : 16'(-nq_q[k]);
      end else begin
        unit_v[k] = (nq_q[k] > 46'd32767) ? 16'h7FFF : nq_q[k][15:0];
      end
    end
    out_next.status         = status_q;
    out_next.contact_count  = count_q;
    out_next.largest_depth  = maxd_q;
    out_next.smallest_depth = mind_q;
    out_next.mean_x         = mean_v[0];
    out_next.mean_y         = mean_v[1];
    out_next.mean_z         = mean_v[2];
    out_next.unit_normal_x  = unit_v[0];
    out_next.unit_normal_y  = unit_v[1];
    out_next.unit_normal_z  = unit_v[2];
    out_next.normal_valid   = nz;
  end

  assign out_data_o = out_q;

endmodule

// ----- sv/contact_manifold_accumulator.sv -----
// Top level of the contact manifold accumulator: controller plus datapath.
// One request at a time: the next is accepted only once the last one's result is loaded. After
// acceptance the duplicate check walks the stored points, then the update, mean divider, root
// and normal divider run in turn; full and duplicate requests skip the update. The 35-step mean
// divider, 31-step root and 46-step divider dominate; a result waits to load while the last is held.
// Reset is asynchronous, active low: store empty, sums and depths cleared, merge distance 66.
module contact_manifold_accumulator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [30:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cma_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cma_pkg::out_t out_data_o
);

  cma_pkg::cmd_t  cmd;
  cma_pkg::stat_t stat;

  cma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/cma_checker.sv -----
// Port-level checker for the contact manifold accumulator and its bind.
module cma_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cma_pkg::out_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == cma_pkg::StCleared |->
      out_data_o.contact_count == 4'd0 && out_data_o.largest_depth == 31'd0 &&
      out_data_o.smallest_depth == cma_pkg::DepthOnes && !out_data_o.normal_valid)
    else $error("clear did not empty the manifold");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.normal_valid |->
      out_data_o.unit_normal_x == 16'd0 && out_data_o.unit_normal_y == 16'd0 &&
      out_data_o.unit_normal_z == 16'd0)
    else $error("invalid normal is not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == cma_pkg::StFull |->
      out_data_o.contact_count == 4'(cma_pkg::MaxPoints))
    else $error("full status with store not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.contact_count != 4'd0 |->
      out_data_o.smallest_depth <= out_data_o.largest_depth)
    else $error("depth trackers out of order");

endmodule

bind contact_manifold_accumulator cma_checker u_cma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- sim/tb_contact_manifold_accumulator.sv -----
// Self-checking testbench for the contact manifold accumulator.
module tb_contact_manifold_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [30:0]   cfg_wdata_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  cma_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  cma_pkg::out_t out_data_o;

  always #1 clk_i = ~clk_i;

  contact_manifold_accumulator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // Predictor state.
  logic [30:0]        merge_dist;
  logic signed [31:0] pts_x [cma_pkg::MaxPoints];
  logic signed [31:0] pts_y [cma_pkg::MaxPoints];
  logic signed [31:0] pts_z [cma_pkg::MaxPoints];
  int unsigned        n_pts;
  longint             psum [3];
  longint             nsum [3];
  logic [30:0]        deep_max, deep_min;

  cma_pkg::in_t  pending_requests [$];
  cma_pkg::out_t expected_results [$];
  int   errors = 0;
  longint cycles = 0;
  bit   long_hold = 1'b0;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit near_point(longint x, longint y, longint z);
    longint unsigned lim, dx, dy, dz;
    lim = merge_dist;
    for (int i = 0; i < n_pts; i++) begin
      dx = mag(x - pts_x[i]);
      dy = mag(y - pts_y[i]);
      dz = mag(z - pts_z[i]);
      if (dx < lim && dy < lim && dz < lim && dx*dx + dy*dy + dz*dz < lim*lim) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_manifold();
    n_pts = 0;
    for (int k = 0; k < 3; k++) begin
      psum[k] = 0;
      nsum[k] = 0;
    end
    deep_max = '0;
    deep_min = cma_pkg::DepthOnes;
  endfunction

  function automatic cma_pkg::out_t manifold_summary(cma_pkg::in_t req);
    cma_pkg::out_t r;
    longint unsigned a, m2, len, q;
    longint v;
    r = '0;
    if (req.operation == cma_pkg::OpClear) begin
      clear_manifold();
      r.status = cma_pkg::StCleared;
    end else if (n_pts >= cma_pkg::MaxPoints) begin
      r.status = cma_pkg::StFull;
    end else if (near_point(req.point_x, req.point_y, req.point_z)) begin
      r.status = cma_pkg::StDup;
    end else begin
      a = mag(longint'(req.depth));
      if (a > cma_pkg::DepthOnes) a = cma_pkg::DepthOnes;
      pts_x[n_pts] = req.point_x;
      pts_y[n_pts] = req.point_y;
      pts_z[n_pts] = req.point_z;
      psum[0] += req.point_x;
      psum[1] += req.point_y;
      psum[2] += req.point_z;
      nsum[0] += req.normal_x;
      nsum[1] += req.normal_y;
      nsum[2] += req.normal_z;
      if (a > deep_max) deep_max = a[30:0];
      if (a < deep_min) deep_min = a[30:0];
      n_pts++;
      r.status = cma_pkg::StAdded;
    end
    r.contact_count = n_pts[3:0];
    r.largest_depth = deep_max;
    r.smallest_depth = deep_min;
    if (n_pts != 0) begin
      r.mean_x = 32'(psum[0] / longint'(n_pts));
      r.mean_y = 32'(psum[1] / longint'(n_pts));
      r.mean_z = 32'(psum[2] / longint'(n_pts));
    end
    m2 = 0;
    for (int k = 0; k < 3; k++) m2 += mag(nsum[k]) * mag(nsum[k]);
    if (m2 != 0) begin
      len = int_sqrt(m2 << 24);
      for (int k = 0; k < 3; k++) begin
        q = (mag(nsum[k]) << 27) / len;
        if (nsum[k] < 0) v = q > 32768 ? -32768 : -longint'(q);
        else v = q > 32767 ? 32767 : longint'(q);
        if (k == 0) r.unit_normal_x = v[15:0];
        else if (k == 1) r.unit_normal_y = v[15:0];
        else r.unit_normal_z = v[15:0];
      end
      r.normal_valid = 1'b1;
    end
    return r;
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(manifold_summary(in_data_i));
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_requests.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(12, 1);
            if ($urandom_range(1, 0)) gap_left <= $urandom_range(200, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern plus one long hold-off while the sender keeps offering.
  int stall_phase = 0, hold_count = 0;
  always @(posedge clk_i) begin
    if (long_hold && hold_count < 1500) begin
      hold_count <= hold_count + 1;
      out_ready_i <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 97;
      out_ready_i <= (stall_phase < 40) ? 1'b1 : ($urandom_range(3, 0) != 0);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    cma_pkg::out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data_o.status); errors++;
        end
        if (out_data_o.contact_count !== e.contact_count) begin
          $error("contact_count exp %0d got %0d", e.contact_count,
                 out_data_o.contact_count); errors++;
        end
        if (out_data_o.largest_depth !== e.largest_depth) begin
          $error("largest_depth exp %h got %h", e.largest_depth,
                 out_data_o.largest_depth); errors++;
        end
        if (out_data_o.smallest_depth !== e.smallest_depth) begin
          $error("smallest_depth exp %h got %h", e.smallest_depth,
                 out_data_o.smallest_depth); errors++;
        end
        if (out_data_o.mean_x !== e.mean_x) begin
          $error("mean_x exp %h got %h", e.mean_x, out_data_o.mean_x); errors++;
        end
        if (out_data_o.mean_y !== e.mean_y) begin
          $error("mean_y exp %h got %h", e.mean_y, out_data_o.mean_y); errors++;
        end
        if (out_data_o.mean_z !== e.mean_z) begin
          $error("mean_z exp %h got %h", e.mean_z, out_data_o.mean_z); errors++;
        end
        if (out_data_o.unit_normal_x !== e.unit_normal_x) begin
          $error("unit_normal_x exp %h got %h", e.unit_normal_x,
                 out_data_o.unit_normal_x); errors++;
        end
        if (out_data_o.unit_normal_y !== e.unit_normal_y) begin
          $error("unit_normal_y exp %h got %h", e.unit_normal_y,
                 out_data_o.unit_normal_y); errors++;
        end
        if (out_data_o.unit_normal_z !== e.unit_normal_z) begin
          $error("unit_normal_z exp %h got %h", e.unit_normal_z,
                 out_data_o.unit_normal_z); errors++;
        end
        if (out_data_o.normal_valid !== e.normal_valid) begin
          $error("normal_valid exp %0d got %0d", e.normal_valid,
                 out_data_o.normal_valid); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 4_000_000) begin
      $display("tb_contact_manifold_accumulator: errors");
      $finish;
    end
  end

  function automatic cma_pkg::in_t make_add(logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] z);
    cma_pkg::in_t r;
    r.operation = cma_pkg::OpAdd;
    r.point_x = x;
    r.point_y = y;
    r.point_z = z;
    r.normal_x = 16'($urandom);
    r.normal_y = 16'($urandom);
    r.normal_z = 16'($urandom);
    r.depth = $urandom;
    return r;
  endfunction

  function automatic cma_pkg::in_t clear_request();
    cma_pkg::in_t r;
    r = '0;
    r.operation = cma_pkg::OpClear;
    r.point_x = $urandom;
    r.depth = $urandom;
    return r;
  endfunction

  // Well-formed manifold: a clear, then points clustered around a center so that
  // some land within the merge radius and the store often fills.
  task automatic queue_manifold(int unsigned spread);
    logic signed [31:0] cx, cy, cz;
    cma_pkg::in_t r;
    cx = $urandom;
    cy = $urandom;
    cz = $urandom;
    pending_requests.push_back(clear_request());
    repeat ($urandom_range(12, 1)) begin
      r = make_add(cx + $signed($urandom_range(2*spread, 0)) - $signed(spread),
                   cy + $signed($urandom_range(2*spread, 0)) - $signed(spread),
                   cz + $signed($urandom_range(2*spread, 0)) - $signed(spread));
      if ($urandom_range(9, 0) == 0) r.depth = 32'sh8000_0000;
      if ($urandom_range(9, 0) == 0) begin
        r.normal_x = 16'sh8000;
        r.normal_y = 16'sh8000;
        r.normal_z = 16'sh8000;
      end
      pending_requests.push_back(r);
    end
  endtask

  task automatic drain_and_write(logic [30:0] new_dist);
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= new_dist;
    merge_dist = new_dist;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    cma_pkg::in_t r;
    logic [30:0] dists [5];
    merge_dist = cma_pkg::MergeDistReset;
    clear_manifold();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty aggregates, extremes, zero normal sum, duplicates, full store.
    pending_requests.push_back(clear_request());
    r = make_add(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    r.depth = 32'sh8000_0000;
    r.normal_x = 16'sh7FFF; r.normal_y = 16'sh0; r.normal_z = 16'sh0;
    pending_requests.push_back(r);
    r = make_add(32'sh7FFF_FFFF, 32'sh8000_0000, 10);
    pending_requests.push_back(r);
    r = make_add(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    r.depth = 0;
    r.normal_x = 16'sh8001; r.normal_y = 16'sh0; r.normal_z = 16'sh0;
    pending_requests.push_back(r);
    r = make_add(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    r.depth = 32'sh7FFF_FFFF;
    r.normal_x = 16'sh8000; r.normal_y = 16'sh8000; r.normal_z = 16'sh8000;
    pending_requests.push_back(r);
    for (int i = 0; i < 6; i++) pending_requests.push_back(make_add(i * 1000, -i * 999, i));
    pending_requests.push_back(make_add(1, 2, 3));
    pending_requests.push_back(make_add(1, 2, 3));
    pending_requests.push_back(clear_request());
    pending_requests.push_back(make_add(5, 5, 5));
    pending_requests.push_back(make_add(5, 5, 5));

    // Zero radius: identical points are never merged.
    drain_and_write('0);
    pending_requests.push_back(make_add(5, 5, 5));
    pending_requests.push_back(make_add(5, 5, 5));
    pending_requests.push_back(clear_request());

    dists[0] = 31'h7FFF_FFFF;
    dists[1] = 31'd66;
    dists[2] = 31'd4000;
    dists[3] = 31'h0010_0000;
    dists[4] = 31'd1;
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_write(dists[ph]);
      if (ph == 2) long_hold = 1'b1;
      while (pending_requests.size() < 400) begin
        if ($urandom_range(9, 0) < 8) begin
          queue_manifold(ph == 0 ? 32'h7FFF_FFFF : $urandom_range(8000, 1));
        end else if ($urandom_range(1, 0)) begin
          r = make_add($urandom, $urandom, $urandom);
          pending_requests.push_back(r);
        end else begin
          pending_requests.push_back(clear_request());
        end
      end
    end

    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_contact_manifold_accumulator: clean");
    end else begin
      $display("tb_contact_manifold_accumulator: errors");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/cma_pkg.sv
sv/cma_ctrl.sv
sv/cma_dp.sv
sv/contact_manifold_accumulator.sv
sv/cma_checker.sv
sim/tb_contact_manifold_accumulator.sv
